### rtl/positional_array_table_engine_unit_assert.svh
// Assertion macros for the table engine.
`ifndef POSITIONAL_ARRAY_TABLE_ENGINE_UNIT_ASSERT_SVH
`define POSITIONAL_ARRAY_TABLE_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define PATE_ASSERT_IMPL(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("table engine check failed");

// Next-cycle implication, disabled while in reset.
`define PATE_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("table engine check failed");

`endif

### rtl/pate_pkg.sv
package pate_pkg;

    localparam int unsigned DEPTH_DEF = 64;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned POS_W    = 7;
    localparam int unsigned FUNC_W   = 3;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned INDEX_W  = 6;
    localparam int unsigned MAX_DUMP = 64;

    // value, position, padded to whole bytes
    localparam int unsigned S_TDATA_W = ((VALUE_W + POS_W + 7) / 8) * 8;
    // index, data, minimum, padded to whole bytes
    localparam int unsigned M_TDATA_W = ((INDEX_W + 2 * VALUE_W + 7) / 8) * 8;

    localparam logic [FUNC_W-1:0] FN_INSERT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_DUMP   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_SEARCH = 3'd2;
    localparam logic [FUNC_W-1:0] FN_DELETE = 3'd3;
    localparam logic [FUNC_W-1:0] FN_MINMAX = 3'd4;
    localparam logic [FUNC_W-1:0] FN_UPDATE = 3'd5;

    localparam logic [STATUS_W-1:0] STS_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STS_BADPOS   = 3'd1;
    localparam logic [STATUS_W-1:0] STS_NOTFOUND = 3'd2;
    localparam logic [STATUS_W-1:0] STS_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] STS_FULL     = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_EMIT,
        S_DUMP,
        S_SRCH,
        S_MINMAX,
        S_INS,
        S_INS_PUT,
        S_DEL
    } pate_state_t;

endpackage

### rtl/positional_array_table_engine_unit.sv
// Packed table of DEPTH signed 32-bit words with a live count, driven by one request per
// input transaction (insert, dump, search, delete, min/max, update). A small sequencer walks
// the table through a single-port-read, single-port-write memory with registered read data,
// one entry per cycle unless a dump waits on the output; the block takes no new request
// until the current one has finished. After accept and decode, insert shifts entries
// pos..n-1 up by one, then writes the value (an append writes at decode); delete shifts
// the entries above pos down by one (none for the last entry); search reads to a match or
// the end; min/max reads all n entries; update writes at decode. Each result, errors too,
// then loads once the output register is free; dump loads min(n,64) results, one per entry
// (n the live count, pos the position). The result sits in an output register, so the next
// request is accepted while it waits. Only entries below n are read: no clearing pass.
module positional_array_table_engine_unit #(
    parameter int unsigned DEPTH = pate_pkg::DEPTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // value [31:0], position [38:32], zero pad [39]
    input  logic [pate_pkg::S_TDATA_W-1:0]         s_tdata,
    // func [2:0]
    input  logic [pate_pkg::FUNC_W-1:0]            s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // index [5:0], data [37:6], minimum [69:38], zero pad [71:70]
    output logic [pate_pkg::M_TDATA_W-1:0]         m_tdata,
    // status [2:0]
    output logic [pate_pkg::STATUS_W-1:0]          m_tuser,
    output logic                                   m_tlast
);
    import pate_pkg::*;

`include "positional_array_table_engine_unit_assert.svh"

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;
    localparam logic [PW-1:0] DUMP_LAST_IDX = PW'(MAX_DUMP - 1);
    localparam logic [CW-1:0] FULL_COUNT    = CW'(DEPTH);

    pate_state_t state_reg, state_next;

    logic [FUNC_W-1:0]          func_reg;
    logic signed [VALUE_W-1:0]  val_reg;
    logic [POS_W-1:0]           pos_reg;
    logic [CW-1:0]              count_reg, count_next;
    logic [AW-1:0]              ptr_reg, ptr_next;

    logic [STATUS_W-1:0]        res_status_reg, res_status_next;
    logic [INDEX_W-1:0]         res_index_reg, res_index_next;
    logic signed [VALUE_W-1:0]  res_data_reg, res_data_next;
    logic signed [VALUE_W-1:0]  res_min_reg, res_min_next;

    logic                       out_valid_reg;
    logic [STATUS_W-1:0]        out_status_reg;
    logic [INDEX_W-1:0]         out_index_reg;
    logic signed [VALUE_W-1:0]  out_data_reg;
    logic signed [VALUE_W-1:0]  out_min_reg;
    logic                       out_last_reg;

    logic signed [VALUE_W-1:0]  mem [DEPTH];
    logic signed [VALUE_W-1:0]  rdata_reg;
    logic                       rd_en, wr_en;
    logic [AW-1:0]              rd_addr, wr_addr;
    logic signed [VALUE_W-1:0]  wr_data;

    logic                       out_load, out_free;
    logic [STATUS_W-1:0]        o_status;
    logic [INDEX_W-1:0]         o_index;
    logic signed [VALUE_W-1:0]  o_data;
    logic signed [VALUE_W-1:0]  o_min;
    logic                       o_last;

    logic [PW-1:0]              pos_ext, cnt_ext, ptr_ext, cnt_m1_ext;
    logic [CW-1:0]              cnt_dec;
    logic [AW-1:0]              cnt_m1, pos_a, ptr_inc, ptr_dec;
    logic                       in_accept, empty, full, dump_last;

    assign in_accept  = s_tvalid && s_tready;
    assign out_free   = !out_valid_reg || m_tready;
    assign pos_ext    = PW'(pos_reg);
    assign cnt_ext    = PW'(count_reg);
    assign ptr_ext    = PW'(ptr_reg);
    assign cnt_dec    = count_reg - CW'(1);
    assign cnt_m1     = cnt_dec[AW-1:0];
    assign cnt_m1_ext = PW'(cnt_dec);
    assign pos_a      = pos_ext[AW-1:0];
    assign ptr_inc    = ptr_reg + AW'(1);
    assign ptr_dec    = ptr_reg - AW'(1);
    assign empty      = (count_reg == '0);
    assign full       = (count_reg == FULL_COUNT);
    assign dump_last  = (ptr_ext == cnt_m1_ext) || (ptr_ext == DUMP_LAST_IDX);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_data_next   = res_data_reg;
        res_min_next    = res_min_reg;
        rd_en           = 1'b0;
        rd_addr         = ptr_inc;
        wr_en           = 1'b0;
        wr_addr         = ptr_reg;
        wr_data         = rdata_reg;
        out_load        = 1'b0;
        o_status        = res_status_reg;
        o_index         = res_index_reg;
        o_data          = res_data_reg;
        o_min           = res_min_reg;
        o_last          = 1'b1;
        s_tready        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                res_status_next = STS_OK;
                res_index_next  = '0;
                res_data_next   = '0;
                res_min_next    = '0;
                state_next      = S_EMIT;
                case (func_reg)
                    FN_INSERT:
                    begin
                        if (pos_ext > cnt_ext)
                        begin
                            res_status_next = STS_BADPOS;
                        end
                        else if (full)
                        begin
                            res_status_next = STS_FULL;
                        end
                        else if (pos_ext == cnt_ext)
                        begin
                            // append: nothing to move
                            wr_en      = 1'b1;
                            wr_addr    = pos_a;
                            wr_data    = val_reg;
                            count_next = count_reg + CW'(1);
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = cnt_m1;
                            ptr_next   = cnt_m1;
                            state_next = S_INS;
                        end
                    end
                    FN_DUMP, FN_SEARCH, FN_MINMAX:
                    begin
                        if (empty)
                        begin
                            res_status_next = STS_EMPTY;
                        end
                        else
                        begin
                            rd_en    = 1'b1;
                            rd_addr  = '0;
                            ptr_next = '0;
                            if (func_reg == FN_DUMP)
                            begin
                                state_next = S_DUMP;
                            end
                            else if (func_reg == FN_SEARCH)
                            begin
                                state_next = S_SRCH;
                            end
                            else
                            begin
                                state_next = S_MINMAX;
                            end
                        end
                    end
                    FN_DELETE:
                    begin
                        if (empty)
                        begin
                            res_status_next = STS_EMPTY;
                        end
                        else if (pos_ext >= cnt_ext)
                        begin
                            res_status_next = STS_BADPOS;
                        end
                        else if (pos_ext == cnt_m1_ext)
                        begin
                            // last entry: just drop it
                            count_next = cnt_dec;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = pos_a + AW'(1);
                            ptr_next   = pos_a + AW'(1);
                            state_next = S_DEL;
                        end
                    end
                    FN_UPDATE:
                    begin
                        if (empty)
                        begin
                            res_status_next = STS_EMPTY;
                        end
                        else if (pos_ext >= cnt_ext)
                        begin
                            res_status_next = STS_BADPOS;
                        end
                        else
                        begin
                            wr_en   = 1'b1;
                            wr_addr = pos_a;
                            wr_data = val_reg;
                        end
                    end
                    default:
                    begin
                        // unused code: no result
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DUMP:
            begin
                o_status = STS_OK;
                o_index  = ptr_ext[INDEX_W-1:0];
                o_data   = rdata_reg;
                o_min    = '0;
                o_last   = dump_last;
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (dump_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        ptr_next = ptr_inc;
                    end
                end
            end
            S_SRCH:
            begin
                if (rdata_reg == val_reg)
                begin
                    res_index_next = ptr_ext[INDEX_W-1:0];
                    state_next     = S_EMIT;
                end
                else if (ptr_reg == cnt_m1)
                begin
                    res_status_next = STS_NOTFOUND;
                    state_next      = S_EMIT;
                end
                else
                begin
                    rd_en    = 1'b1;
                    ptr_next = ptr_inc;
                end
            end
            S_MINMAX:
            begin
                // running max in res_data, running min in res_min
                if (ptr_reg == '0 || res_data_reg < rdata_reg)
                begin
                    res_data_next = rdata_reg;
                end
                if (ptr_reg == '0 || rdata_reg < res_min_reg)
                begin
                    res_min_next = rdata_reg;
                end
                if (ptr_reg == cnt_m1)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    rd_en    = 1'b1;
                    ptr_next = ptr_inc;
                end
            end
            S_INS:
            begin
                // move entry ptr up by one, walking down towards pos
                wr_en   = 1'b1;
                wr_addr = ptr_inc;
                if (ptr_reg == pos_a)
                begin
                    state_next = S_INS_PUT;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = ptr_dec;
                    ptr_next = ptr_dec;
                end
            end
            S_INS_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_a;
                wr_data    = val_reg;
                count_next = count_reg + CW'(1);
                state_next = S_EMIT;
            end
            S_DEL:
            begin
                // move entry ptr down by one, walking up to the end
                wr_en   = 1'b1;
                wr_addr = ptr_dec;
                if (ptr_reg == cnt_m1)
                begin
                    count_next = cnt_dec;
                    state_next = S_EMIT;
                end
                else
                begin
                    rd_en    = 1'b1;
                    ptr_next = ptr_inc;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            func_reg <= s_tuser;
            val_reg  <= s_tdata[VALUE_W-1:0];
            pos_reg  <= s_tdata[VALUE_W+POS_W-1:VALUE_W];
        end
        ptr_reg        <= ptr_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        res_data_reg   <= res_data_next;
        res_min_reg    <= res_min_next;
        if (out_load)
        begin
            out_status_reg <= o_status;
            out_index_reg  <= o_index;
            out_data_reg   <= o_data;
            out_min_reg    <= o_min;
            out_last_reg   <= o_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {(M_TDATA_W - INDEX_W - 2 * VALUE_W)'(0),
                       out_min_reg, out_data_reg, out_index_reg};

    `PATE_ASSERT_IMPL(a_count_range, clk, rst_n, 1'b1, count_reg <= FULL_COUNT)
    `PATE_ASSERT_IMPL(a_no_overwrite, clk, rst_n, out_load, !m_tvalid || m_tready)
    `PATE_ASSERT_NEXT(a_insert_grows, clk, rst_n, state_reg == S_INS_PUT,
                      count_reg == CW'($past(count_reg) + CW'(1)))
    `PATE_ASSERT_NEXT(a_last_ends, clk, rst_n, out_load && o_last, state_reg == S_IDLE)

endmodule

### tb/tb_positional_array_table_engine_unit.sv
`timescale 1ns / 1ps

module tb_positional_array_table_engine_unit;
    import pate_pkg::*;

    localparam int unsigned TBL_DEPTH = DEPTH_DEF;
    localparam logic [FUNC_W-1:0] FN_SPARE6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE7 = 3'd7;
    localparam int unsigned TAIL_CYCLES = 200;

    typedef enum {MIX_GROW, MIX_BALANCED, MIX_SHRINK} op_mix_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  idx;
        logic [VALUE_W-1:0]  data;
        logic [VALUE_W-1:0]  minimum;
        logic                last;
    } table_result_t;

    typedef struct packed {
        logic [FUNC_W-1:0]   fn;
        logic [VALUE_W-1:0]  value;
        logic [POS_W-1:0]    pos;
        logic                hand_set;
        logic [STATUS_W-1:0] sts;
    } script_row_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [FUNC_W-1:0]    s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;
    logic                 m_tlast;

    logic [VALUE_W-1:0] shadow_tbl [TBL_DEPTH];
    int unsigned        shadow_n = 0;
    table_result_t      step_results[$];
    table_result_t      due_results[$];
    int unsigned        fail_count = 0;
    bit                 quiet = 1'b0;

    // hand-set rows carry the status only; every other field is zero with last set
    script_row_t script [0:24] = '{
        '{FN_DUMP,   32'd0,         7'd0,   1'b1, STS_EMPTY},
        '{FN_SEARCH, 32'd0,         7'd0,   1'b1, STS_EMPTY},
        '{FN_DELETE, 32'd0,         7'd0,   1'b1, STS_EMPTY},
        '{FN_UPDATE, 32'd1,         7'd0,   1'b1, STS_EMPTY},
        '{FN_MINMAX, 32'd0,         7'd0,   1'b1, STS_EMPTY},
        '{FN_INSERT, 32'd5,         7'd1,   1'b1, STS_BADPOS},
        '{FN_INSERT, 32'h7fff_ffff, 7'd0,   1'b1, STS_OK},
        '{FN_INSERT, 32'h8000_0000, 7'd0,   1'b1, STS_OK},
        '{FN_INSERT, 32'd0,         7'd2,   1'b0, STS_OK},
        '{FN_INSERT, 32'hffff_ffff, 7'd1,   1'b0, STS_OK},
        '{FN_MINMAX, 32'd0,         7'd0,   1'b0, STS_OK},
        '{FN_DUMP,   32'd0,         7'd0,   1'b0, STS_OK},
        '{FN_SEARCH, 32'd0,         7'd0,   1'b0, STS_OK},
        '{FN_SEARCH, 32'h8000_0000, 7'd0,   1'b0, STS_OK},
        '{FN_SEARCH, 32'd12345,     7'd0,   1'b1, STS_NOTFOUND},
        '{FN_DELETE, 32'd0,         7'd4,   1'b1, STS_BADPOS},
        '{FN_UPDATE, 32'd0,         7'd127, 1'b1, STS_BADPOS},
        '{FN_INSERT, 32'd0,         7'd64,  1'b1, STS_BADPOS},
        '{FN_UPDATE, 32'd5,         7'd1,   1'b0, STS_OK},
        '{FN_SPARE6, 32'hffff_ffff, 7'd127, 1'b0, STS_OK},
        '{FN_SPARE7, 32'd0,         7'd0,   1'b0, STS_OK},
        '{FN_DELETE, 32'd0,         7'd3,   1'b0, STS_OK},
        '{FN_DELETE, 32'd0,         7'd0,   1'b0, STS_OK},
        '{FN_INSERT, 32'h55,        7'd2,   1'b0, STS_OK},
        '{FN_DUMP,   32'd0,         7'd0,   1'b0, STS_OK}
    };

    always #5 clk = ~clk;

    positional_array_table_engine_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    function automatic table_result_t make_result(logic [STATUS_W-1:0] st, int unsigned ix,
                                                  logic [VALUE_W-1:0] d,
                                                  logic [VALUE_W-1:0] mn, logic lst);
        table_result_t r;
        r.status  = st;
        r.idx     = INDEX_W'(ix);
        r.data    = d;
        r.minimum = mn;
        r.last    = lst;
        return r;
    endfunction

    // Updates the shadow table and leaves the results of one request in step_results.
    function automatic void compute_table_results(logic [FUNC_W-1:0] fn, logic [VALUE_W-1:0] v,
                                                  int unsigned p);
        int unsigned n;
        int unsigned i;
        logic [VALUE_W-1:0] hi;
        logic [VALUE_W-1:0] lo;
        bit hit;
        n = shadow_n;
        hit = 1'b0;
        step_results.delete();
        case (fn)
            FN_INSERT:
                if (p > n)
                    step_results.push_back(make_result(STS_BADPOS, 0, '0, '0, 1'b1));
                else if (n >= TBL_DEPTH)
                    step_results.push_back(make_result(STS_FULL, 0, '0, '0, 1'b1));
                else
                begin
                    for (i = n; i > p; i--)
                        shadow_tbl[i] = shadow_tbl[i-1];
                    shadow_tbl[p] = v;
                    shadow_n = n + 1;
                    step_results.push_back(make_result(STS_OK, 0, '0, '0, 1'b1));
                end
            FN_DUMP:
                if (n == 0)
                    step_results.push_back(make_result(STS_EMPTY, 0, '0, '0, 1'b1));
                else
                    for (i = 0; i < n && i < MAX_DUMP; i++)
                        step_results.push_back(make_result(STS_OK, i, shadow_tbl[i], '0,
                                               (i + 1 == n) || (i + 1 == MAX_DUMP)));
            FN_SEARCH:
                if (n == 0)
                    step_results.push_back(make_result(STS_EMPTY, 0, '0, '0, 1'b1));
                else
                begin
                    for (i = 0; i < n && !hit; i++)
                        if (shadow_tbl[i] == v)
                        begin
                            hit = 1'b1;
                            step_results.push_back(make_result(STS_OK, i, '0, '0, 1'b1));
                        end
                    if (!hit)
                        step_results.push_back(make_result(STS_NOTFOUND, 0, '0, '0, 1'b1));
                end
            FN_DELETE:
                if (n == 0)
                    step_results.push_back(make_result(STS_EMPTY, 0, '0, '0, 1'b1));
                else if (p >= n)
                    step_results.push_back(make_result(STS_BADPOS, 0, '0, '0, 1'b1));
                else
                begin
                    for (i = p; i + 1 < n; i++)
                        shadow_tbl[i] = shadow_tbl[i+1];
                    shadow_n = n - 1;
                    step_results.push_back(make_result(STS_OK, 0, '0, '0, 1'b1));
                end
            FN_MINMAX:
                if (n == 0)
                    step_results.push_back(make_result(STS_EMPTY, 0, '0, '0, 1'b1));
                else
                begin
                    hi = shadow_tbl[0];
                    lo = shadow_tbl[0];
                    for (i = 1; i < n; i++)
                    begin
                        if ($signed(shadow_tbl[i]) > $signed(hi)) hi = shadow_tbl[i];
                        if ($signed(shadow_tbl[i]) < $signed(lo)) lo = shadow_tbl[i];
                    end
                    step_results.push_back(make_result(STS_OK, 0, hi, lo, 1'b1));
                end
            FN_UPDATE:
                if (n == 0)
                    step_results.push_back(make_result(STS_EMPTY, 0, '0, '0, 1'b1));
                else if (p >= n)
                    step_results.push_back(make_result(STS_BADPOS, 0, '0, '0, 1'b1));
                else
                begin
                    shadow_tbl[p] = v;
                    step_results.push_back(make_result(STS_OK, 0, '0, '0, 1'b1));
                end
            default: ;  // spare codes are dropped by the block
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                   input logic [VALUE_W-1:0] want);
        $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    task automatic check_result(input table_result_t got);
        table_result_t want;
        if (due_results.size() == 0)
        begin
            report_mismatch("unexpected result, status", VALUE_W'(got.status), '0);
            return;
        end
        want = due_results.pop_front();
        if (got.status !== want.status)
            report_mismatch("status", VALUE_W'(got.status), VALUE_W'(want.status));
        if (got.idx !== want.idx)
            report_mismatch("index", VALUE_W'(got.idx), VALUE_W'(want.idx));
        if (got.data !== want.data)       report_mismatch("data", got.data, want.data);
        if (got.minimum !== want.minimum) report_mismatch("minimum", got.minimum, want.minimum);
        if (got.last !== want.last)
            report_mismatch("last", VALUE_W'(got.last), VALUE_W'(want.last));
    endtask

    // valid stays up across back-to-back transactions; it only drops ahead of a gap
    task automatic send_request(input logic [FUNC_W-1:0] fn, input logic [VALUE_W-1:0] v,
                                input logic [POS_W-1:0] p, input logic hand_set,
                                input logic [STATUS_W-1:0] sts);
        int unsigned gap;
        if ($urandom_range(0, 11) == 0) quiet = !quiet;
        gap = quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({p, v});
        s_tuser  <= fn;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        compute_table_results(fn, v, p);
        if (hand_set)
            due_results.push_back(make_result(sts, 0, '0, '0, 1'b1));
        else
            foreach (step_results[k]) due_results.push_back(step_results[k]);
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (due_results.size() != 0) @(posedge clk);
    endtask

    task automatic random_request(input op_mix_t mix, output bit counted);
        int unsigned n;
        int unsigned roll;
        int unsigned ins_w;
        int unsigned del_w;
        logic [FUNC_W-1:0]  fn;
        logic [VALUE_W-1:0] v;
        logic [POS_W-1:0]   p;
        n = shadow_n;
        case (mix)
            MIX_GROW:     begin ins_w = 55; del_w = 8;  end
            MIX_BALANCED: begin ins_w = 28; del_w = 28; end
            default:      begin ins_w = 8;  del_w = 55; end
        endcase
        roll = $urandom_range(0, ins_w + del_w + 36);
        if (roll < ins_w)
            fn = FN_INSERT;
        else if (roll < ins_w + del_w)
            fn = FN_DELETE;
        else
        begin
            roll = roll - ins_w - del_w;
            if (roll < 6)       fn = FN_DUMP;
            else if (roll < 16) fn = FN_SEARCH;
            else if (roll < 22) fn = FN_MINMAX;
            else if (roll < 32) fn = FN_UPDATE;
            else                fn = roll[0] ? FN_SPARE6 : FN_SPARE7;
        end

        // searches mostly hit, inserts sometimes repeat a value or hit the signed extremes
        v = $urandom();
        roll = $urandom_range(0, 99);
        if (n > 0 && fn == FN_SEARCH && roll < 60)
            v = shadow_tbl[$urandom_range(0, n - 1)];
        else if (n > 0 && fn == FN_INSERT && roll < 15)
            v = shadow_tbl[$urandom_range(0, n - 1)];
        else if (fn == FN_INSERT && roll < 25)
            case (roll[1:0])
                2'd0:    v = 32'h8000_0000;
                2'd1:    v = 32'h7fff_ffff;
                2'd2:    v = 32'h0;
                default: v = 32'hffff_ffff;
            endcase

        if ($urandom_range(0, 99) < 85)
            p = (fn == FN_INSERT) ? POS_W'($urandom_range(0, n))
                                  : (n > 0 ? POS_W'($urandom_range(0, n - 1)) : '0);
        else
            p = POS_W'($urandom_range(0, 127));

        counted = (fn != FN_SPARE6) && (fn != FN_SPARE7);
        send_request(fn, v, p, 1'b0, STS_OK);
    endtask

    initial
    begin : result_sink
        int unsigned stall;
        table_result_t got;
        @(posedge rst_n);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 13);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            got.status  = m_tuser;
            got.idx     = m_tdata[INDEX_W-1:0];
            got.data    = m_tdata[INDEX_W +: VALUE_W];
            got.minimum = m_tdata[INDEX_W+VALUE_W +: VALUE_W];
            got.last    = m_tlast;
            check_result(got);
        end
    end

    initial
    begin : stimulus
        int unsigned done;
        bit counted;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[k])
            send_request(script[k].fn, script[k].value, script[k].pos,
                         script[k].hand_set, script[k].sts);
        hold_until_drained();

        done = 0;
        while (done < 50)
        begin
            random_request(MIX_GROW, counted);
            if (counted) done++;
        end

        // top the table up, then poke at it while full
        while (shadow_n < TBL_DEPTH)
            send_request(FN_INSERT, $urandom(), POS_W'($urandom_range(0, shadow_n)),
                         1'b0, STS_OK);
        send_request(FN_INSERT, 32'h1234_5678, 7'd64, 1'b1, STS_FULL);
        send_request(FN_INSERT, 32'h0, 7'd0, 1'b1, STS_FULL);
        send_request(FN_INSERT, 32'h0, 7'd65, 1'b1, STS_BADPOS);
        send_request(FN_DUMP, 32'h0, 7'd0, 1'b0, STS_OK);
        send_request(FN_MINMAX, 32'h0, 7'd0, 1'b0, STS_OK);
        send_request(FN_UPDATE, $urandom(), 7'd63, 1'b0, STS_OK);
        send_request(FN_DELETE, 32'h0, 7'd64, 1'b1, STS_BADPOS);

        done = 0;
        while (done < 40)
        begin
            random_request(MIX_SHRINK, counted);
            if (counted) done++;
        end
        done = 0;
        while (done < 20)
        begin
            random_request(MIX_BALANCED, counted);
            if (counted) done++;
        end

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && due_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
